[sv/uart_bang_hash_command_parser_unit_assert.svh]
// Assertion macros for the checker module.
`ifndef UART_BANG_HASH_COMMAND_PARSER_UNIT_ASSERT_SVH
`define UART_BANG_HASH_COMMAND_PARSER_UNIT_ASSERT_SVH

// The expression must never be true while out of reset.
`define UBH_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ubh assertion failed");

// The antecedent implies the consequent in the same cycle.
`define UBH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubh assertion failed");

// The antecedent implies the consequent in the next cycle.
`define UBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubh assertion failed");

`endif

[sv/ubh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ubh_pkg;

    localparam int FRAME_CAPACITY_DEF = 10;

    // Only the first bytes of a frame can take part in a command match.
    localparam int KEEP_BYTES = 3;

    localparam logic [7:0] CHR_BANG = 8'h21;
    localparam logic [7:0] CHR_HASH = 8'h23;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_SP   = 8'h20;
    localparam logic [7:0] CHR_TAB  = 8'h09;
    localparam logic [7:0] CHR_R    = 8'h52;
    localparam logic [7:0] CHR_S    = 8'h53;
    localparam logic [7:0] CHR_T    = 8'h54;
    localparam logic [7:0] CHR_O    = 8'h4F;
    localparam logic [7:0] CHR_K    = 8'h4B;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_RST  = 2'd1,
        CMD_OK   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic       is_eol;
        logic       is_bang;
        logic       is_hash;
        logic       is_blank;
        logic [7:0] data;
    } t_class;

    typedef struct packed {
        t_cmd cmd;
        logic err;
    } t_result;

endpackage

`default_nettype wire

[sv/ubh_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ubh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubh_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_event;
    logic       error_event;

    modport source (output valid, output command_event, output error_event, input ready);
    modport sink (input valid, input command_event, input error_event, output ready);
endinterface

`default_nettype wire

[sv/uart_bang_hash_command_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command parser for framed serial commands "!RST#" and "!OK#".
// The i_rx channel carries one received character per transaction. The
// o_res channel returns exactly one transaction per character, carrying a
// command_event pulse (none, reset request, acknowledge) and an
// error_event pulse for a bad frame or a malformed line.
// Each character is classified and captured in an input register; when the
// result register is free, the frame state (mode, fill count, stray flag
// and the first command bytes) is updated and the outcome is captured in
// the result register, which drives o_res. Throughput is one character
// per cycle while o_res is not stalled; the frame update between the input
// register and the result register is combinational.
// Reset empties both registers and returns the parser to waiting for a
// frame start with no stray input recorded.
// When the receiver stalls, the result holds on o_res and one more
// character can still be taken into the input register; after that
// i_rx.ready drops until the result transaction completes.
module uart_bang_hash_command_parser_unit #(
    parameter int FRAME_CAPACITY = ubh_pkg::FRAME_CAPACITY_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ubh_byte_if.sink      i_rx,
    ubh_result_if.source  o_res
);
    import ubh_pkg::*;

    t_class  n_class, r_class;
    logic    r_in_valid;
    t_result n_result, r_result;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;

    // The result register can load when empty or being read this cycle.
    assign out_free   = !r_out_valid || o_res.ready;
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    ubh_classify u_classify (
        .i_byte  (i_rx.rx_byte),
        .o_class (n_class)
    );

    ubh_frame #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_class   (r_class),
        .o_result  (n_result)
    );

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_class <= n_class;
        end
    end

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.command_event = r_result.cmd;
    assign o_res.error_event   = r_result.err;

endmodule

`default_nettype wire

[sv/ubh_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module ubh_classify (
    input  wire logic [7:0]      i_byte,
    output ubh_pkg::t_class      o_class
);
    import ubh_pkg::*;

    always_comb begin
        o_class.is_eol   = (i_byte == CHR_CR) || (i_byte == CHR_LF);
        o_class.is_bang  = (i_byte == CHR_BANG);
        o_class.is_hash  = (i_byte == CHR_HASH);
        o_class.is_blank = (i_byte == CHR_SP) || (i_byte == CHR_TAB);
        o_class.data     = i_byte;
    end

endmodule

`default_nettype wire

[sv/ubh_frame.sv]
`timescale 1ns / 1ps
`default_nettype none

module ubh_frame #(
    parameter int FRAME_CAPACITY = ubh_pkg::FRAME_CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire ubh_pkg::t_class i_class,
    output ubh_pkg::t_result     o_result
);
    import ubh_pkg::*;

    localparam int STORE_SIZE = FRAME_CAPACITY - 1;
    localparam int FILL_W     = $clog2(FRAME_CAPACITY);
    localparam int IDX_W      = $clog2(KEEP_BYTES);

    logic              r_in_frame, n_in_frame;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_stray, n_stray;
    logic [7:0]        r_word [KEEP_BYTES];
    logic              n_wr_en;
    logic              match_rst, match_ok;

    // Exact length and byte compare against the two known commands.
    assign match_rst = (r_fill == FILL_W'(3)) && (r_word[0] == CHR_R)
                    && (r_word[1] == CHR_S) && (r_word[2] == CHR_T);
    assign match_ok  = (r_fill == FILL_W'(2)) && (r_word[0] == CHR_O)
                    && (r_word[1] == CHR_K);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_fill       = r_fill;
        n_stray      = r_stray;
        n_wr_en      = 1'b0;
        o_result.cmd = CMD_NONE;
        o_result.err = 1'b0;
        if (i_class.is_eol) begin
            if (r_stray) begin
                o_result.err = 1'b1;
                n_stray      = 1'b0;
            end
        end else if (!r_in_frame) begin
            if (i_class.is_bang) begin
                n_in_frame = 1'b1;
                n_fill     = '0;
                n_stray    = 1'b0;
            end else if (!i_class.is_blank) begin
                n_stray = 1'b1;
            end
        end else if (i_class.is_hash) begin
            if (match_rst) begin
                o_result.cmd = CMD_RST;
            end else if (match_ok) begin
                o_result.cmd = CMD_OK;
            end else if (r_fill != '0) begin
                o_result.err = 1'b1;
            end
            n_in_frame = 1'b0;
            n_fill     = '0;
            n_stray    = 1'b0;
        end else if (i_class.is_bang) begin
            n_fill  = '0;
            n_stray = 1'b0;
        end else if (r_fill < FILL_W'(STORE_SIZE)) begin
            n_wr_en = (r_fill < FILL_W'(KEEP_BYTES));
            n_fill  = r_fill + FILL_W'(1);
        end else begin
            // Overflow drops the frame without a report.
            n_in_frame = 1'b0;
            n_fill     = '0;
            n_stray    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_stray    <= 1'b0;
        end else if (i_advance) begin
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_stray    <= n_stray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && n_wr_en) begin
            r_word[r_fill[IDX_W-1:0]] <= i_class.data;
        end
    end

endmodule

`default_nettype wire

[sv/ubh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "uart_bang_hash_command_parser_unit_assert.svh"

module ubh_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_cmd,
    input wire logic       i_err
);
    import ubh_pkg::*;

    // A frame end reports a command or an error, never both.
    `UBH_ASSERT_NEVER(a_cmd_and_err, i_clk, i_rst_n, i_out_valid && (i_cmd != CMD_NONE) && i_err)

    // No command code beyond acknowledge is produced.
    `UBH_ASSERT_NEVER(a_cmd_code, i_clk, i_rst_n, i_out_valid && (i_cmd > CMD_OK))

    // With the result stage empty, the parser always takes a character.
    `UBH_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // A stalled result stays put.
    `UBH_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cmd) && $stable(i_err))

    // An offered character stays offered until it is taken.
    `UBH_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !i_in_ready, i_in_valid)

endmodule

bind uart_bang_hash_command_parser_unit ubh_checker u_ubh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_cmd       (o_res.command_event),
    .i_err       (o_res.error_event)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the framed command parser. Every accepted character is run
// through a predictor of the frame state, and the expected outcome is queued.
// A checker process compares each result transaction with the oldest queued
// outcome. Directed tests cover the commands and the corner cases of framing;
// random tests send mostly frames mixed with noise and broken frames, with
// both channels idling at random in all but the second random run.
module tb_top;
    import ubh_pkg::*;

    localparam int BODY_DEPTH   = FRAME_CAPACITY_DEF - 1;
    localparam int ITEM_TARGET  = 650;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 4;

    logic clk;
    logic rst_n;

    ubh_byte_if   rx_if ();
    ubh_result_if res_if ();

    uart_bang_hash_command_parser_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // Predicted parser state.
    logic       framing;
    logic [7:0] body_mem [BODY_DEPTH];
    int         body_len;
    logic       loose_text;

    t_result pending_results[$];
    int      fail_count;
    int      chars_sent;
    logic    gaps_on;
    logic    hold_req;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Works out the outcome of one character and advances the frame state.
    function automatic t_result parse_char(input logic [7:0] c);
        t_result r;
        r.cmd = CMD_NONE;
        r.err = 1'b0;
        if (c == CHR_CR || c == CHR_LF) begin
            // A line end reports stray text and is never stored.
            if (loose_text) begin
                r.err = 1'b1;
                loose_text = 1'b0;
            end
        end else if (!framing) begin
            if (c == CHR_BANG) begin
                framing = 1'b1;
                body_len = 0;
                loose_text = 1'b0;
            end else if (c != CHR_SP && c != CHR_TAB) begin
                loose_text = 1'b1;
            end
        end else if (c == CHR_HASH) begin
            if (body_len == 3 && body_mem[0] == CHR_R && body_mem[1] == CHR_S
                    && body_mem[2] == CHR_T) begin
                r.cmd = CMD_RST;
            end else if (body_len == 2 && body_mem[0] == CHR_O
                    && body_mem[1] == CHR_K) begin
                r.cmd = CMD_OK;
            end else if (body_len != 0) begin
                r.err = 1'b1;
            end
            framing = 1'b0;
            body_len = 0;
            loose_text = 1'b0;
        end else if (c == CHR_BANG) begin
            // A second start throws away what was collected so far.
            body_len = 0;
            loose_text = 1'b0;
        end else if (body_len < BODY_DEPTH) begin
            body_mem[body_len] = c;
            body_len++;
        end else begin
            // Overflow drops the frame and the character with it.
            framing = 1'b0;
            body_len = 0;
            loose_text = 1'b0;
        end
        return r;
    endfunction

    // Offers one character and waits for its transaction.
    task automatic send_byte(input logic [7:0] c);
        logic ignored;
        if (gaps_on && $urandom_range(0, 99) < 8) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= c;
        do @(posedge clk); while (!rx_if.ready);
        ignored = !framing && (c == CHR_SP || c == CHR_TAB);
        pending_results.push_back(parse_char(c));
        if (!ignored) chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 4))
            0:       return CHR_R;
            1:       return CHR_S;
            2:       return CHR_T;
            3:       return CHR_O;
            default: return CHR_K;
        endcase
    endfunction

    // Biased toward the characters the parser treats specially.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:       return CHR_BANG;
            1:       return CHR_HASH;
            2:       return CHR_CR;
            3:       return CHR_LF;
            4:       return CHR_SP;
            5:       return CHR_TAB;
            6:       return pick_letter();
            7:       return pick_letter();
            8:       return 8'h00;
            9:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Checks results and drives the result channel's ready.
    initial begin : result_checker
        t_result want;
        int      hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: command_event %0d error_event %0d",
                           res_if.command_event, res_if.error_event);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.command_event !== want.cmd) begin
                        $error("command_event: expected %0d, actual %0d",
                               want.cmd, res_if.command_event);
                        fail_count++;
                    end
                    if (res_if.error_event !== want.err) begin
                        $error("error_event: expected %0d, actual %0d",
                               want.err, res_if.error_event);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (gaps_on) begin
                res_if.ready <= ($urandom_range(0, 99) >= 8);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_commands();
        send_text("!RST#");
        send_text("!O");
        send_byte(CHR_CR);
        send_text("K#");
        send_text("!#");
        // Restart inside a frame, then a zero byte in an unknown frame.
        send_text("!A!");
        send_byte(8'h00);
        send_byte(CHR_HASH);
        send_text("!RS!RST#");
    endtask

    task automatic test_lines();
        send_byte(8'hFF);
        send_byte(CHR_LF);
        send_byte(8'h00);
        send_byte(CHR_CR);
        send_byte(CHR_SP);
        send_byte(CHR_TAB);
        send_byte(CHR_CR);
        // A frame start forgets earlier stray text.
        send_text("x!OK#");
        send_byte(CHR_LF);
    endtask

    task automatic test_overflow();
        send_text("!AAAAAAAAA#");
        send_text("!RSTRSTRSTX#");
        send_byte(CHR_LF);
        send_text("!OKOKOKOKOK");
        send_text("!OK#");
    endtask

    task automatic send_random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            if ($urandom_range(0, 4) == 0) send_byte(pick_char());
            send_byte(CHR_BANG);
            case (kind)
                0, 1: send_text("RST");
                2, 3: send_text("OK");
                4, 5: begin
                    len = $urandom_range(0, 4);
                    repeat (len) send_byte(pick_letter());
                end
                6: begin
                    len = $urandom_range(8, 11);
                    repeat (len) send_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    len = $urandom_range(0, 6);
                    repeat (len) send_byte(pick_char());
                end
            endcase
            if ($urandom_range(0, 5) != 0) send_byte(CHR_HASH);
            if ($urandom_range(0, 2) == 0)
                send_byte($urandom_range(0, 1) ? CHR_CR : CHR_LF);
        end else if (kind == 8) begin
            len = $urandom_range(1, 4);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte($urandom_range(0, 1) ? CHR_CR : CHR_LF);
        end else begin
            len = $urandom_range(1, 5);
            repeat (len) send_byte(pick_char());
        end
    endtask

    // The receiver holds off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (6) send_random_frame();
    endtask

    task automatic test_random(input int upto, input logic with_gaps);
        gaps_on = with_gaps;
        while (chars_sent < upto) send_random_frame();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial begin
        framing = 1'b0;
        body_len = 0;
        loose_text = 1'b0;
        fail_count = 0;
        chars_sent = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_lines();
        test_overflow();
        test_backpressure();
        test_random(ITEM_TARGET / 2, 1'b1);
        test_random(ITEM_TARGET * 3 / 4, 1'b0);
        test_random(ITEM_TARGET, 1'b1);
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/ubh_pkg.sv
sv/ubh_if.sv
sv/ubh_classify.sv
sv/ubh_frame.sv
sv/uart_bang_hash_command_parser_unit.sv
sv/ubh_checker.sv
test/tb_top.sv
